// ===== rtl/core/shape_fill_rasterizer_defines.svh =====
// Assertion macros shared by the rasterizer RTL.
// SFR_ASSERT is gated by the asynchronous reset; SFR_ASSERT_ALWAYS also
// checks while reset is held.
`ifndef SHAPE_FILL_RASTERIZER_DEFINES_SVH
`define SHAPE_FILL_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS

`define SFR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("shape_fill_rasterizer: assertion failed");

`define SFR_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("shape_fill_rasterizer: assertion failed during reset or run");

`else

`define SFR_ASSERT(lbl, prop)

`define SFR_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/core/sfr_pkg.sv =====
package sfr_pkg;

	// Default frame store geometry.
	localparam int unsigned MAX_COLUMNS_DEF = 64;
	localparam int unsigned MAX_ROWS_DEF    = 64;

	// Register values after reset; the store powers up holding a space.
	localparam logic [6:0] RESET_CANVAS_WIDTH  = 7'd64;
	localparam logic [6:0] RESET_CANVAS_HEIGHT = 7'd64;
	localparam logic [7:0] RESET_SYMBOL        = 8'd32;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CANVAS_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_CANVAS_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_EMPTY_SYMBOL  = 2'd2;

	// Command codes.
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_RECT   = 2'd1,
		OP_CIRCLE = 2'd2,
		OP_READ   = 2'd3
	} opcode_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SWEEP,
		ST_FILL,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/sfr_ram.sv =====
module sfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = sfr_pkg::MAX_COLUMNS_DEF * sfr_pkg::MAX_ROWS_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/shape_fill_rasterizer.sv =====
// Character frame store with clear, filled rectangle, filled circle and pixel read.
// Input channel: in_valid/in_stall carry one command beat (opcode, pos_x, pos_y,
// size_w, size_h, radius, symbol). Output channel: out_valid/out_stall carry one
// result beat (status, pixel_value) for every command, in command order.
// Configuration: cfg_valid/cfg_ready write canvas_width, canvas_height and
// empty_symbol by cfg_index; cfg_ready is always high.
// Timing: one command is worked on at a time. A read or a rejected shape goes from
// its command beat straight to ST_DONE; a rectangle or circle first passes through
// ST_FILL, one pixel of its bounding box at a time, and a clear through ST_SWEEP over
// every store entry. ST_DONE loads the result beat once the output register is free,
// then ST_IDLE takes the next command beat. The single write port of the frame memory
// takes one pixel a cycle in ST_FILL and ST_SWEEP.
// Reset: a clearing pass writes a space into every store entry; in_stall stays high
// meanwhile.
// Stall: the result sits in an output register until taken. The next command is
// accepted meanwhile; its result waits until the output register is free.
`include "shape_fill_rasterizer_defines.svh"

module shape_fill_rasterizer #(
	parameter int unsigned MAX_COLUMNS = sfr_pkg::MAX_COLUMNS_DEF,
	parameter int unsigned MAX_ROWS    = sfr_pkg::MAX_ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	// command channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [5:0] pos_x,
	input  logic [5:0] pos_y,
	input  logic [6:0] size_w,
	input  logic [6:0] size_h,
	input  logic [5:0] radius,
	input  logic [7:0] symbol,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       status,
	output logic [7:0] pixel_value
);

	localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sfr_pkg::state_t state_q, state_d;

	logic [6:0] canvas_width_q, canvas_height_q;
	logic [7:0] empty_symbol_q;
	logic [6:0] cw_eff, ch_eff;

	logic [7:0] px8, py8, cw8, ch8;
	logic [7:0] hw8, hh8, rx_lo, rx_hi, ry_lo, ry_hi, r8, cx_lo, cx_hi, cy_lo, cy_hi;
	logic       rect_bad, circ_bad, read_bad, in_accept;

	logic [AW-1:0] addr_q;
	logic [7:0]    sweep_val_q;
	logic [6:0]    x_q, y_q, x_lo_q, x_hi_q, y_hi_q, cx_q, cy_q;
	logic [AW-1:0] row_q;
	logic          circ_q, status_q, rd_sel_q;
	logic [7:0]    sym_q;
	logic [11:0]   r2_q;

	logic [6:0]  dx, dy;
	logic [13:0] dx2, dy2;
	logic        in_circle, x_last, y_last, sweep_last, out_free, out_load;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	logic       out_valid_q, out_status_q;
	logic [7:0] out_pixel_q;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= sfr_pkg::RESET_CANVAS_WIDTH;
			canvas_height_q <= sfr_pkg::RESET_CANVAS_HEIGHT;
			empty_symbol_q  <= sfr_pkg::RESET_SYMBOL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfr_pkg::CFG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data[6:0];
				sfr_pkg::CFG_CANVAS_HEIGHT: canvas_height_q <= cfg_data[6:0];
				sfr_pkg::CFG_EMPTY_SYMBOL:  empty_symbol_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Canvas size in use, clamped to 1 .. store size.
	always_comb begin
		if (canvas_width_q == 7'd0) begin
			cw_eff = 7'd1;
		end else if (32'(canvas_width_q) > MAX_COLUMNS) begin
			cw_eff = 7'(MAX_COLUMNS);
		end else begin
			cw_eff = canvas_width_q;
		end
		if (canvas_height_q == 7'd0) begin
			ch_eff = 7'd1;
		end else if (32'(canvas_height_q) > MAX_ROWS) begin
			ch_eff = 7'(MAX_ROWS);
		end else begin
			ch_eff = canvas_height_q;
		end
	end

	// Shape spans and bound checks on the incoming command.
	always_comb begin
		px8 = {2'b00, pos_x};
		py8 = {2'b00, pos_y};
		cw8 = {1'b0, cw_eff};
		ch8 = {1'b0, ch_eff};
		hw8 = {2'b00, size_w[6:1]};
		hh8 = {2'b00, size_h[6:1]};
		rx_lo = size_w[0] ? px8 - hw8 : px8;
		rx_hi = size_w[0] ? px8 + hw8 : px8 + {1'b0, size_w} - 8'd1;
		ry_lo = size_h[0] ? py8 - hh8 : py8;
		ry_hi = size_h[0] ? py8 + hh8 : py8 + {1'b0, size_h} - 8'd1;
		rect_bad = (pos_x == 6'd0) || (pos_y == 6'd0) || (size_w == 7'd0) ||
			(size_h == 7'd0) || (size_w[0] && (px8 < hw8)) ||
			(size_h[0] && (py8 < hh8)) || (rx_hi >= cw8) || (ry_hi >= ch8);
		r8 = {2'b00, radius};
		cx_lo = px8 - r8;
		cx_hi = px8 + r8;
		cy_lo = py8 - r8;
		cy_hi = py8 + r8;
		circ_bad = (pos_x == 6'd0) || (pos_y == 6'd0) || (radius == 6'd0) ||
			(px8 < r8) || (py8 < r8) || (cx_hi >= cw8) || (cy_hi >= ch8);
		read_bad = (px8 >= cw8) || (py8 >= ch8);
	end

	// Circle membership of the current pixel.
	always_comb begin
		dx = (x_q >= cx_q) ? x_q - cx_q : cx_q - x_q;
		dy = (y_q >= cy_q) ? y_q - cy_q : cy_q - y_q;
		dx2 = 14'(dx) * 14'(dx);
		dy2 = 14'(dy) * 14'(dy);
		in_circle = ({1'b0, dx2} + {1'b0, dy2}) <= 15'(r2_q);
	end

	assign x_last     = (x_q == x_hi_q);
	assign y_last     = (y_q == y_hi_q);
	assign sweep_last = (addr_q == AW'(DEPTH - 1));
	assign out_free   = !out_valid_q || !out_stall;
	assign in_accept  = in_valid && !in_stall;
	assign ram_raddr  = AW'(pos_y) * AW'(MAX_COLUMNS) + AW'(pos_x);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfr_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory port control and output load.
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = sweep_val_q;
		out_load  = 1'b0;
		unique case (state_q) inside
			sfr_pkg::ST_INIT, sfr_pkg::ST_SWEEP: begin
				ram_we = 1'b1;
				if (sweep_last) begin
					state_d = (state_q == sfr_pkg::ST_INIT) ? sfr_pkg::ST_IDLE
						: sfr_pkg::ST_DONE;
				end
			end
			sfr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (sfr_pkg::opcode_t'(opcode))
						sfr_pkg::OP_CLEAR:  state_d = sfr_pkg::ST_SWEEP;
						sfr_pkg::OP_RECT:   state_d = rect_bad ? sfr_pkg::ST_DONE
							: sfr_pkg::ST_FILL;
						sfr_pkg::OP_CIRCLE: state_d = circ_bad ? sfr_pkg::ST_DONE
							: sfr_pkg::ST_FILL;
						sfr_pkg::OP_READ: begin
							ram_re  = 1'b1;
							state_d = sfr_pkg::ST_DONE;
						end
						default: state_d = sfr_pkg::ST_DONE;
					endcase
				end
			end
			sfr_pkg::ST_FILL: begin
				ram_we    = !circ_q || in_circle;
				ram_waddr = row_q + AW'(x_q);
				ram_wdata = sym_q;
				if (x_last && y_last) begin
					state_d = sfr_pkg::ST_DONE;
				end
			end
			sfr_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = sfr_pkg::ST_IDLE;
				end
			end
			default: state_d = sfr_pkg::ST_INIT;
		endcase
	end

	// Sweep address and fill value; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			sweep_val_q <= sfr_pkg::RESET_SYMBOL;
		end else if (in_accept && (opcode == sfr_pkg::OP_CLEAR)) begin
			addr_q      <= '0;
			sweep_val_q <= empty_symbol_q;
		end else if ((state_q == sfr_pkg::ST_INIT) || (state_q == sfr_pkg::ST_SWEEP)) begin
			addr_q <= addr_q + AW'(1);
		end
	end

	// Command capture and the box scan of rectangle and circle fills.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			circ_q <= (opcode == sfr_pkg::OP_CIRCLE);
			sym_q  <= symbol;
			cx_q   <= {1'b0, pos_x};
			cy_q   <= {1'b0, pos_y};
			r2_q   <= 12'(radius) * 12'(radius);
			if (opcode == sfr_pkg::OP_CIRCLE) begin
				x_q    <= cx_lo[6:0];
				x_lo_q <= cx_lo[6:0];
				x_hi_q <= cx_hi[6:0];
				y_q    <= cy_lo[6:0];
				y_hi_q <= cy_hi[6:0];
				row_q  <= AW'(cy_lo[6:0]) * AW'(MAX_COLUMNS);
			end else begin
				x_q    <= rx_lo[6:0];
				x_lo_q <= rx_lo[6:0];
				x_hi_q <= rx_hi[6:0];
				y_q    <= ry_lo[6:0];
				y_hi_q <= ry_hi[6:0];
				row_q  <= AW'(ry_lo[6:0]) * AW'(MAX_COLUMNS);
			end
			case (sfr_pkg::opcode_t'(opcode))
				sfr_pkg::OP_RECT:   status_q <= rect_bad;
				sfr_pkg::OP_CIRCLE: status_q <= circ_bad;
				sfr_pkg::OP_READ:   status_q <= read_bad;
				default:            status_q <= 1'b0;
			endcase
			rd_sel_q <= (opcode == sfr_pkg::OP_READ) && !read_bad;
		end else if (state_q == sfr_pkg::ST_FILL) begin
			if (x_last) begin
				x_q <= x_lo_q;
				if (!y_last) begin
					y_q   <= y_q + 7'd1;
					row_q <= row_q + AW'(MAX_COLUMNS);
				end
			end else begin
				x_q <= x_q + 7'd1;
			end
		end
	end

	// Frame store.
	sfr_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Result register: holds a beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_pixel_q  <= rd_sel_q ? ram_rdata : 8'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign pixel_value = out_pixel_q;

	// The frame memory is never read and written in the same cycle.
	`SFR_ASSERT(a_no_rw_overlap, !(ram_we && ram_re))
	// A result beat only appears after the finishing state.
	`SFR_ASSERT(a_load_from_done, $rose(out_valid_q) |-> $past(state_q == sfr_pkg::ST_DONE))
	// Every write lands inside the store.
	`SFR_ASSERT(a_write_in_store, ram_we |-> (32'(ram_waddr) < DEPTH))
	// No result is offered while the power-up clearing pass runs.
	`SFR_ASSERT_ALWAYS(a_init_quiet, (state_q == sfr_pkg::ST_INIT) |-> !out_valid_q)

endmodule
